>>> src/toroidal_life_generations_top_defines.svh
// Assertion macros shared by the toroidal life block.
`ifndef TOROIDAL_LIFE_GENERATIONS_TOP_DEFINES_SVH
`define TOROIDAL_LIFE_GENERATIONS_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLG_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tlg: implication check failed");
// next-cycle implication
`define TLG_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tlg: next-cycle check failed");
`else
`define TLG_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define TLG_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> src/tlg_pkg.sv
// Shared constants and types of the toroidal life block.
package tlg_pkg;

	localparam int unsigned ROW_W      = 64;  // row bus width
	localparam int unsigned COL_W      = 6;   // column index
	localparam int unsigned CNT_W      = 7;   // row/width counts, 0..127
	localparam int unsigned GEN_W      = 16;  // generation counter
	localparam int unsigned IDX_W      = 6;   // emitted row index
	localparam int unsigned NBR_W      = 4;   // neighbor count 0..8
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned DEF_MAX_WIDTH  = 64;
	localparam int unsigned DEF_MAX_HEIGHT = 64;
	localparam int unsigned RESULT_LIMIT   = 64;

	localparam logic [CNT_W-1:0] RST_GRID_WIDTH  = 7'd64;
	localparam logic [CNT_W-1:0] RST_GRID_HEIGHT = 7'd64;
	localparam logic [GEN_W-1:0] RST_GEN_COUNT   = 16'd1;

	// B3/S23
	localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
	localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_WIDTH  = 2'd0,
		CFG_GRID_HEIGHT = 2'd1,
		CFG_GEN_COUNT   = 2'd2
	} tlg_cfg_reg_t;

	// 3x3 neighborhood of one cell; bit 0 west, bit 1 center, bit 2 east
	typedef struct packed {
		logic [2:0] dn;
		logic [2:0] mid;
		logic [2:0] up;
	} tlg_nbhd_t;

endpackage

>>> src/tlg_if.sv
// Request channels of the toroidal life block: row input and grid result.
interface tlg_row_if import tlg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_cells;

	modport source (output valid, output row_cells, input ready);
	modport sink   (input valid, input row_cells, output ready);
endinterface

interface tlg_res_if import tlg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] out_row_cells;
	logic [IDX_W-1:0] out_row_index;
	logic             last_row;

	modport source (output valid, output out_row_cells, output out_row_index,
		output last_row, input ready);
	modport sink   (input valid, input out_row_cells, input out_row_index,
		input last_row, output ready);
endinterface

>>> src/tlg_lane.sv
// One cell lane: counts live neighbors and applies the B3/S23 rule.
module tlg_lane import tlg_pkg::*; (
	input  tlg_nbhd_t nbhd,
	output logic      alive
);

	logic [NBR_W-1:0] count;

	assign count = NBR_W'(nbhd.up[0]) + NBR_W'(nbhd.up[1]) + NBR_W'(nbhd.up[2])
		+ NBR_W'(nbhd.mid[0]) + NBR_W'(nbhd.mid[2])
		+ NBR_W'(nbhd.dn[0]) + NBR_W'(nbhd.dn[1]) + NBR_W'(nbhd.dn[2]);

	assign alive = (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && nbhd.mid[1]);

endmodule

>>> src/tlg_row_engine.sv
// Row engine: one lane per column with toroidal wrap, merged into the next row.
module tlg_row_engine import tlg_pkg::*; #(
	parameter int unsigned LANES = DEF_MAX_WIDTH
) (
	input  logic [ROW_W-1:0] up_row,
	input  logic [ROW_W-1:0] mid_row,
	input  logic [ROW_W-1:0] dn_row,
	input  logic [COL_W-1:0] last_col,
	output logic [ROW_W-1:0] next_row,
	output logic             changed
);

	logic             up_edge;
	logic             mid_edge;
	logic             dn_edge;
	logic [LANES-1:0] lane_out;

	// column width-1, the west neighbor of column 0
	assign up_edge  = up_row[last_col];
	assign mid_edge = mid_row[last_col];
	assign dn_edge  = dn_row[last_col];

	for (genvar x = 0; x < LANES; x++) begin : g_lane
		localparam logic [COL_W-1:0] XI = COL_W'(x);
		logic [2:0] west;  // {dn, mid, up}
		logic [2:0] east;
		tlg_nbhd_t  nb;
		logic       alive;

		if (x == 0) begin : g_w
			assign west = {dn_edge, mid_edge, up_edge};
		end else begin : g_w
			assign west = {dn_row[x-1], mid_row[x-1], up_row[x-1]};
		end

		if (x == LANES - 1) begin : g_e
			assign east = {dn_row[0], mid_row[0], up_row[0]};
		end else begin : g_e
			assign east = (XI == last_col) ? {dn_row[0], mid_row[0], up_row[0]}
				: {dn_row[x+1], mid_row[x+1], up_row[x+1]};
		end

		assign nb.up  = {east[0], up_row[x], west[0]};
		assign nb.mid = {east[1], mid_row[x], west[1]};
		assign nb.dn  = {east[2], dn_row[x], west[2]};

		tlg_lane u_lane (
			.nbhd  (nb),
			.alive (alive)
		);

		// columns past the width in use stay dead
		assign lane_out[x] = alive && (XI <= last_col);
	end

	// merge
	assign next_row = ROW_W'(lane_out);
	assign changed  = (next_row != mid_row);

endmodule

>>> src/toroidal_life_generations_top.sv
// Top level of the toroidal life block: load, generation sequencer, emit.
//
// Use: configure grid_width, grid_height and generation_count on the plain
// write port (cfg_we, cfg_index, cfg_data) while the block is idle; any write
// restarts the grid load. Then send grid_height row requests on "rows", one
// row of cells each. Rows are taken one per cycle. After the last row the
// block runs the B3/S23 rule on a torus and returns the final grid on
// "results", one request per row from row 0, last_row set on the final one.
// Dataflow per phase, h = rows in use, G = generations run:
//   load    one row per cycle
//   compute per generation, one memory read per cycle streams
//           the previous grid past a three-row window, all columns are
//           evaluated at once by the lane array and one row is written back
//           per cycle; the run ends early once a generation changes nothing
//   emit    the first row passes the memory read register, then the output
//           register, then one row per cycle while taken
// Reset: registers return to width 64, height 64, one generation; the load
// restarts at row 0. Grid memory is not cleared; every row is written first.
// A stalled result holds in the output register and stops the emit reads;
// the block takes the next grid's rows while the last result still waits.
`include "toroidal_life_generations_top_defines.svh"

module toroidal_life_generations_top import tlg_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tlg_row_if.sink               rows,
	tlg_res_if.source             results
);

	// rows actually storable, capped at the result limit
	localparam int unsigned ROWS   = (MAX_HEIGHT < RESULT_LIMIT) ? MAX_HEIGHT : RESULT_LIMIT;
	localparam int unsigned ROW_AW = $clog2(ROWS);
	localparam int unsigned DEPTH  = 2 ** (ROW_AW + 1);  // two banks
	localparam logic [CNT_W-1:0] ROWS_C  = CNT_W'(ROWS);
	localparam logic [CNT_W-1:0] WIDTH_C = CNT_W'(MAX_WIDTH);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_GEN  = 3'b010,
		ST_EMIT = 3'b100
	} tlg_state_t;

	// configuration
	logic [CNT_W-1:0] cfg_w_q;
	logic [CNT_W-1:0] cfg_h_q;
	logic [GEN_W-1:0] cfg_gens_q;
	logic             cfg_hit;

	// effective geometry
	logic [CNT_W-1:0] eff_w;
	logic [CNT_W-1:0] eff_w_m1;
	logic [CNT_W-1:0] eff_h;
	logic [COL_W-1:0] last_col;
	logic [ROW_W-1:0] row_mask;
	logic [ROW_W-1:0] in_masked;

	// control
	tlg_state_t       state_q;
	logic             cur_bank_q;
	logic [CNT_W-1:0] rows_loaded_q;
	logic [CNT_W-1:0] h_q;
	logic [CNT_W-1:0] step_q;
	logic [GEN_W-1:0] gen_left_q;
	logic             chg_q;
	logic [CNT_W-1:0] emit_rd_q;
	logic [CNT_W-1:0] emit_idx_q;
	logic             pend_q;

	logic             in_acc;
	logic             load_done;
	logic             gen_act;
	logic             gen_rd;
	logic             gen_wr;
	logic             gen_end;
	logic             gen_more;
	logic [CNT_W-1:0] gen_row;
	logic             chg_all;
	logic             emit_act;
	logic             emit_rd_en;
	logic             emit_last;
	logic             load_out;

	// window and captured edge rows
	logic [ROW_W-1:0] first_q;   // row 0 of the current grid
	logic [ROW_W-1:0] nfirst_q;  // row 0 of the grid being built
	logic [ROW_W-1:0] last_q;    // last row of the current grid
	logic [ROW_W-1:0] up_q;
	logic [ROW_W-1:0] mid_q;
	logic [ROW_W-1:0] stream;
	logic [ROW_W-1:0] next_row;
	logic             row_changed;

	// grid memory, two banks of at least ROWS rows each
	logic [MAX_WIDTH-1:0]  grid_mem_q [DEPTH];
	logic [MAX_WIDTH-1:0]  rdata_q;
	logic [ROW_W-1:0]      rdata_row;
	logic                  mem_we;
	logic                  mem_re;
	logic [ROW_AW:0]       waddr;
	logic [ROW_AW:0]       raddr;
	logic [ROW_W-1:0]      wdata;

	// output register
	logic             out_valid_q;
	logic [ROW_W-1:0] out_cells_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_last_q;

	// ---------------------------------------------------------------- geometry
	always_comb begin
		if (cfg_w_q == '0)
			eff_w = CNT_W'(1);
		else if (cfg_w_q > WIDTH_C)
			eff_w = WIDTH_C;
		else
			eff_w = cfg_w_q;

		if (cfg_h_q == '0)
			eff_h = CNT_W'(1);
		else if (cfg_h_q > ROWS_C)
			eff_h = ROWS_C;
		else
			eff_h = cfg_h_q;

		for (int x = 0; x < ROW_W; x++)
			row_mask[x] = (CNT_W'(x) < eff_w);
	end

	assign eff_w_m1  = eff_w - CNT_W'(1);
	assign last_col  = eff_w_m1[COL_W-1:0];
	assign in_masked = rows.row_cells & row_mask;

	assign cfg_hit = cfg_we && ((cfg_index == CFG_GRID_WIDTH)
		|| (cfg_index == CFG_GRID_HEIGHT) || (cfg_index == CFG_GEN_COUNT));

	// ---------------------------------------------------------------- control
	assign rows.ready = (state_q == ST_LOAD);
	assign in_acc     = rows.valid && rows.ready;
	assign load_done  = in_acc && (rows_loaded_q == eff_h - CNT_W'(1));

	// Generation: step 0..h-1 issue reads, step 1..h see rows 0..h-1, step h+1
	// feeds row 0 again as the wrapped lower neighbor. Row step-2 is written.
	assign gen_act  = (state_q == ST_GEN);
	assign gen_rd   = gen_act && (step_q < h_q);
	assign gen_wr   = gen_act && (step_q >= CNT_W'(2));
	assign gen_end  = gen_act && (step_q == h_q + CNT_W'(1));
	assign gen_row  = step_q - CNT_W'(2);
	assign stream   = (step_q <= h_q) ? rdata_row : first_q;
	assign chg_all  = chg_q | row_changed;
	assign gen_more = (gen_left_q != GEN_W'(1)) && chg_all;

	tlg_row_engine #(
		.LANES (MAX_WIDTH)
	) u_engine (
		.up_row   (up_q),
		.mid_row  (mid_q),
		.dn_row   (stream),
		.last_col (last_col),
		.next_row (next_row),
		.changed  (row_changed)
	);

	// Emit: one read ahead of the output register
	assign emit_act   = (state_q == ST_EMIT);
	assign load_out   = pend_q && (!out_valid_q || results.ready);
	assign emit_rd_en = emit_act && (emit_rd_q < h_q) && (!pend_q || load_out);
	assign emit_last  = (emit_idx_q == h_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q       <= RST_GRID_WIDTH;
			cfg_h_q       <= RST_GRID_HEIGHT;
			cfg_gens_q    <= RST_GEN_COUNT;
			state_q       <= ST_LOAD;
			cur_bank_q    <= 1'b0;
			rows_loaded_q <= '0;
			h_q           <= CNT_W'(1);
			step_q        <= '0;
			gen_left_q    <= '0;
			chg_q         <= 1'b0;
			emit_rd_q     <= '0;
			emit_idx_q    <= '0;
			pend_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_GRID_WIDTH:  cfg_w_q    <= cfg_data[CNT_W-1:0];
					CFG_GRID_HEIGHT: cfg_h_q    <= cfg_data[CNT_W-1:0];
					CFG_GEN_COUNT:   cfg_gens_q <= cfg_data[GEN_W-1:0];
					default: ;
				endcase
			end

			// a register write aborts a partial load
			if (cfg_hit || load_done)
				rows_loaded_q <= '0;
			else if (in_acc)
				rows_loaded_q <= rows_loaded_q + CNT_W'(1);

			unique case (state_q)
				ST_LOAD: begin
					if (load_done) begin
						h_q        <= eff_h;
						step_q     <= '0;
						chg_q      <= 1'b0;
						gen_left_q <= cfg_gens_q;
						emit_rd_q  <= '0;
						emit_idx_q <= '0;
						pend_q     <= 1'b0;
						state_q    <= (cfg_gens_q == '0) ? ST_EMIT : ST_GEN;
					end
				end
				ST_GEN: begin
					if (gen_end) begin
						cur_bank_q <= ~cur_bank_q;
						gen_left_q <= gen_left_q - GEN_W'(1);
						chg_q      <= 1'b0;
						step_q     <= '0;
						// stop at the count or once the grid is stable
						if (!gen_more)
							state_q <= ST_EMIT;
					end else begin
						step_q <= step_q + CNT_W'(1);
						if (gen_wr)
							chg_q <= chg_all;
					end
				end
				ST_EMIT: begin
					if (emit_rd_en)
						emit_rd_q <= emit_rd_q + CNT_W'(1);
					if (load_out)
						emit_idx_q <= emit_idx_q + CNT_W'(1);
					pend_q <= emit_rd_en || (pend_q && !load_out);
					if (load_out && emit_last)
						state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase

			if (load_out)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- memory
	// loads go to the current bank, a new generation to the other one
	assign mem_we = in_acc || gen_wr;
	assign waddr  = in_acc ? {cur_bank_q, rows_loaded_q[ROW_AW-1:0]}
		: {~cur_bank_q, gen_row[ROW_AW-1:0]};
	assign wdata  = in_acc ? in_masked : next_row;
	assign mem_re = gen_rd || emit_rd_en;
	assign raddr  = gen_act ? {cur_bank_q, step_q[ROW_AW-1:0]}
		: {cur_bank_q, emit_rd_q[ROW_AW-1:0]};
	assign rdata_row = ROW_W'(rdata_q);

	always_ff @(posedge clk) begin
		if (mem_we)
			grid_mem_q[waddr] <= wdata[MAX_WIDTH-1:0];
		if (mem_re)
			rdata_q <= grid_mem_q[raddr];
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (rows_loaded_q == '0)
				first_q <= in_masked;
			if (rows_loaded_q == eff_h - CNT_W'(1))
				last_q <= in_masked;
		end

		if (gen_act && (step_q == CNT_W'(1))) begin
			// prime the window: row above row 0 wraps to the last row
			up_q  <= last_q;
			mid_q <= stream;
		end else if (gen_wr) begin
			up_q  <= mid_q;
			mid_q <= stream;
			if (gen_row == '0)
				nfirst_q <= next_row;
			if (gen_end) begin
				last_q  <= next_row;
				first_q <= (h_q == CNT_W'(1)) ? next_row : nfirst_q;
			end
		end

		if (load_out) begin
			out_cells_q <= rdata_row;
			out_idx_q   <= emit_idx_q[IDX_W-1:0];
			out_last_q  <= emit_last;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.out_row_cells = out_cells_q;
	assign results.out_row_index = out_idx_q;
	assign results.last_row      = out_last_q;

	// ---------------------------------------------------------------- checks
	// every issued emit read is either in the output path or still pending
	`TLG_ASSERT_IMPL(a_emit_count, clk, arst_n, state_q == ST_EMIT, emit_rd_q == emit_idx_q + CNT_W'(pend_q))
	// a generation never writes past the grid it was loaded with
	`TLG_ASSERT_IMPL(a_gen_row_bound, clk, arst_n, gen_wr, gen_row < h_q)
	// a completed grid closes the row input until its last row is in the output register
	`TLG_ASSERT_NEXT(a_load_blocks, clk, arst_n, load_done, !rows.ready)

endmodule
